### rtl/tick_window_signal_order_core_macros.svh
// Assertion macros for the tick window signal order RTL
`ifndef TICK_WINDOW_SIGNAL_ORDER_CORE_MACROS_SVH
`define TICK_WINDOW_SIGNAL_ORDER_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset
`define TWS_ASSERT_IMP(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the cycle after the antecedent
`define TWS_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tws_pkg.sv
// Package with types, constants and defaults of the tick window signal order core
package tws_pkg;

  localparam int INSTRUMENTS_DEF  = 16;
  localparam int WINDOW_DEPTH_DEF = 10;
  localparam int PRICE_BITS_DEF   = 20;

  localparam int INST_W   = 4;
  localparam int PRICE_W  = 20;
  localparam int PCT_W    = 7;
  localparam int HIST_W   = 4;
  localparam int ZLIM_W   = 4;
  localparam int OFFS_W   = 10;
  localparam int CFG_DW   = 20;
  localparam int CFG_AW   = 3;

  localparam logic [CFG_AW-1:0] REG_LOW_BAND  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_HIGH_BAND = 3'd1;
  localparam logic [CFG_AW-1:0] REG_MEAN_PCT  = 3'd2;
  localparam logic [CFG_AW-1:0] REG_MIN_HIST  = 3'd3;
  localparam logic [CFG_AW-1:0] REG_Z_LIMIT   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OFFSET    = 3'd5;

  typedef struct packed {
    logic [INST_W-1:0]  instrument;
    logic [PRICE_W-1:0] price;
  } tick_t;

  typedef struct packed {
    logic [INST_W-1:0]  order_instrument;
    logic [PRICE_W-1:0] order_price;
    logic               is_buy;
  } order_t;

  // Register values handed to the signal judge
  typedef struct packed {
    logic [PRICE_W-1:0] low_band;
    logic [PRICE_W-1:0] high_band;
    logic [PCT_W-1:0]   mean_pct;
    logic [HIST_W-1:0]  min_hist;
    logic [ZLIM_W-1:0]  z_limit;
    logic [OFFS_W-1:0]  offset;
  } cfg_t;

endpackage

### rtl/tws_ram.sv
// Generic single-port-write, single-port-read RAM with registered read
module tws_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 160
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/tws_judge.sv
// Signal judge: exact mean, z and order price arithmetic over accumulated window sums
module tws_judge #(
  parameter int WINDOW_DEPTH = tws_pkg::WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS   = tws_pkg::PRICE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  tws_pkg::cfg_t                       cfg,
  input  logic [PRICE_BITS-1:0]               price,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0]   fill,
  input  logic [PRICE_BITS+$clog2(WINDOW_DEPTH+1)-1:0] sum,
  input  logic [2*PRICE_BITS+$clog2(WINDOW_DEPTH+1)-1:0] sqsum,
  input  logic                                rising,
  output logic                                done,
  output logic                                fire,
  output logic                                buy,
  output logic [tws_pkg::PRICE_W-1:0]         oprice
);
  import tws_pkg::*;

  localparam int NW = $clog2(WINDOW_DEPTH+1);
  localparam int SW = PRICE_BITS + NW;
  localparam int QW = 2*PRICE_BITS + NW;
  localparam int DW = 2*SW + 1;
  localparam int LW = 2*SW + 9;
  localparam logic [PRICE_BITS:0] PMAX = {1'b0, {PRICE_BITS{1'b1}}};

  typedef enum logic [4:0] {
    J_IDLE = 5'b00001,
    J_S1   = 5'b00010,
    J_S2   = 5'b00100,
    J_S3   = 5'b01000,
    J_S4   = 5'b10000
  } jst_t;

  jst_t jst_r, jst_nxt;
  logic [SW-1:0]   np_r;
  logic [SW-1:0]   dev_r;
  logic            above_r, nonzero_r;
  logic [DW-1:0]   nq_r, ss_r, var_r;
  logic [2*SW-1:0] lhs_r;
  logic [LW-1:0]   rhs_r;
  logic [SW+8:0]   m100_r, mhi_r, mlo_r;
  logic            band_r, mean_ok_r, buy_r, sell_r;
  logic [7:0]      zz;
  logic [7:0]      pct_hi, pct_lo;
  logic            mean_fire, mean_below;

  assign zz     = 8'(cfg.z_limit) * 8'(cfg.z_limit);
  assign pct_hi = 8'd100 + 8'(cfg.mean_pct);
  assign pct_lo = 8'd100 - 8'(cfg.mean_pct);

  // Mean band outcome, the lower bound only while the percent is at most 100
  assign mean_fire  = mean_ok_r && ((m100_r > mhi_r) ||
                      ((cfg.mean_pct <= PCT_W'(100)) && (m100_r < mlo_r)));
  assign mean_below = np_r < sum;

  // Step the judge sequence
  always_comb begin
    jst_nxt = jst_r;
    case (jst_r)
      J_IDLE:  if (start) jst_nxt = J_S1;
      J_S1:    jst_nxt = J_S2;
      J_S2:    jst_nxt = J_S3;
      J_S3:    jst_nxt = J_S4;
      J_S4:    jst_nxt = J_IDLE;
      default: jst_nxt = J_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jst_r <= J_IDLE;
    end else begin
      jst_r <= jst_nxt;
    end
  end

  // Datapath: one multiply per operand per step, registered between
  always_ff @(posedge clk) begin
    case (jst_r)
      J_IDLE: begin
        np_r      <= SW'(fill) * SW'(price);
        nq_r      <= DW'(sqsum) * DW'(fill);
        ss_r      <= DW'(sum) * DW'(sum);
        band_r    <= (PRICE_W'(price) < cfg.low_band) || (PRICE_W'(price) > cfg.high_band);
        mean_ok_r <= (32'(cfg.min_hist) <= 32'(fill));
      end
      J_S1: begin
        var_r     <= nq_r - ss_r;
        above_r   <= np_r > sum;
        nonzero_r <= np_r != sum;
        dev_r     <= (np_r > sum) ? np_r - sum : sum - np_r;
        m100_r    <= (SW+9)'(np_r) * (SW+9)'(100);
        mhi_r     <= (SW+9)'(sum) * (SW+9)'(pct_hi);
        mlo_r     <= (SW+9)'(sum) * (SW+9)'(pct_lo);
      end
      J_S2: begin
        lhs_r  <= (2*SW)'(dev_r) * (2*SW)'(dev_r);
        rhs_r  <= LW'(var_r) * LW'(zz);
        buy_r  <= band_r || rising || (mean_fire && mean_below);
        sell_r <= mean_fire && !mean_below;
      end
      J_S3: begin
        if (nonzero_r && (LW'(lhs_r) > rhs_r)) begin
          if (above_r) sell_r <= 1'b1;
          else buy_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Order price with saturation
  logic [PRICE_BITS:0] up_sum;
  assign up_sum = {1'b0, price} + (PRICE_BITS+1)'(cfg.offset);

  always_comb begin
    done = (jst_r == J_S4);
    fire = buy_r || sell_r;
    buy  = buy_r;
    if (buy_r) begin
      oprice = PRICE_W'((up_sum > PMAX) ? PMAX : up_sum);
    end else begin
      oprice = PRICE_W'(({1'b0, price} > (PRICE_BITS+1)'(cfg.offset)) ?
                        up_sum - (PRICE_BITS+1)'(cfg.offset) - (PRICE_BITS+1)'(cfg.offset)
                        : '0);
    end
  end

endmodule

### rtl/tick_window_signal_order_core.sv
// Top level of the tick window signal order core
// Takes one tick word at a time, writes its price into the instrument's ring
// window held in a RAM, then reads the window back one entry per cycle to
// form sum and square sum, and judges four signals exactly. The time from one
// accepted tick to the next grows with the window fill, and with any wait of
// the order word for out_ready; the single window RAM read port and the
// five-step judge set it. At most one order word comes out per tick; the
// next tick is taken once the order word has left the output register.
// No clearing pass: window entries are only read once written.
module tick_window_signal_order_core #(
  parameter int INSTRUMENTS  = tws_pkg::INSTRUMENTS_DEF,
  parameter int WINDOW_DEPTH = tws_pkg::WINDOW_DEPTH_DEF,
  parameter int PRICE_BITS   = tws_pkg::PRICE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  tws_pkg::tick_t              in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output tws_pkg::order_t             out_data,
  input  logic                        cfg_we,
  input  logic [tws_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [tws_pkg::CFG_DW-1:0]  cfg_wdata
);
  import tws_pkg::*;
  `include "tick_window_signal_order_core_macros.svh"

  localparam int IW = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
  localparam int HW = $clog2(WINDOW_DEPTH);
  localparam int NW = $clog2(WINDOW_DEPTH+1);
  localparam int MD = INSTRUMENTS * WINDOW_DEPTH;
  localparam int AW = $clog2(MD);
  localparam int SW = PRICE_BITS + NW;
  localparam int QW = 2*PRICE_BITS + NW;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WRITE = 5'b00010,
    S_READ  = 5'b00100,
    S_JUDGE = 5'b01000,
    S_OUT   = 5'b10000
  } st_t;

  st_t st_r, st_nxt;
  cfg_t cfg_r;
  logic [HW-1:0] head_r [INSTRUMENTS];
  logic [NW-1:0] fill_r [INSTRUMENTS];
  logic [INST_W-1:0] inst_r;
  logic [IW-1:0] w_r;
  logic [PRICE_BITS-1:0] price_r;
  logic [NW-1:0] n_r;
  logic [HW-1:0] rptr_r;
  logic [NW-1:0] rcnt_r;
  logic          rvld_r;
  logic [NW-1:0] dcnt_r;
  logic [SW-1:0] sum_r;
  logic [QW-1:0] sq_r;
  logic [PRICE_BITS-1:0] last1_r, last2_r;
  logic          rise_r;
  logic          jstart_r;
  logic          jdone, jfire, jbuy;
  logic [PRICE_W-1:0] jprice;
  order_t        out_r;
  logic          ovld_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [PRICE_BITS-1:0] rdata;
  logic [IW-1:0] w_in;
  logic [HW-1:0] head_w;

  // Fold the instrument field onto the windows through a small constant table
  always_comb begin
    w_in = '0;
    for (int i = 0; i < 2**INST_W; i++) begin
      if (in_data.instrument == INST_W'(i)) w_in = IW'(i % INSTRUMENTS);
    end
  end

  assign head_w = head_r[w_r];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.low_band  <= PRICE_W'(10500);
      cfg_r.high_band <= PRICE_W'(19500);
      cfg_r.mean_pct  <= PCT_W'(2);
      cfg_r.min_hist  <= HIST_W'(5);
      cfg_r.z_limit   <= ZLIM_W'(2);
      cfg_r.offset    <= OFFS_W'(1);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOW_BAND:  cfg_r.low_band  <= cfg_wdata[PRICE_W-1:0];
        REG_HIGH_BAND: cfg_r.high_band <= cfg_wdata[PRICE_W-1:0];
        REG_MEAN_PCT:  cfg_r.mean_pct  <= cfg_wdata[PCT_W-1:0];
        REG_MIN_HIST:  cfg_r.min_hist  <= cfg_wdata[HIST_W-1:0];
        REG_Z_LIMIT:   cfg_r.z_limit   <= cfg_wdata[ZLIM_W-1:0];
        REG_OFFSET:    cfg_r.offset    <= cfg_wdata[OFFS_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (st_r == S_IDLE);

  // Sequence one tick
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_valid) st_nxt = S_WRITE;
      S_WRITE: st_nxt = S_READ;
      S_READ:  if (rcnt_r == '0 && !rvld_r) st_nxt = S_JUDGE;
      S_JUDGE: if (jdone) st_nxt = jfire ? S_OUT : S_IDLE;
      S_OUT:   if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // RAM port: write the new price, then read the window newest first
  assign we    = (st_r == S_WRITE);
  assign waddr = AW'(32'(w_r) * WINDOW_DEPTH + 32'(head_w));
  assign raddr = AW'(32'(w_r) * WINDOW_DEPTH + 32'(rptr_r));

  tws_ram #(.WIDTH(PRICE_BITS), .DEPTH(MD)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (price_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      ovld_r   <= 1'b0;
      jstart_r <= 1'b0;
      rvld_r   <= 1'b0;
      rcnt_r   <= '0;
      for (int i = 0; i < INSTRUMENTS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else begin
      st_r     <= st_nxt;
      // Kick the judge once the sweep has drained
      jstart_r <= (st_r == S_READ) && (rcnt_r == '0) && !rvld_r;
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            inst_r  <= in_data.instrument;
            w_r     <= w_in;
            price_r <= PRICE_BITS'(in_data.price);
          end
        end
        S_WRITE: begin
          // Advance head and fill, arm the read sweep at the newest entry
          head_r[w_r] <= (32'(head_w) == WINDOW_DEPTH-1) ? '0 : head_w + 1'b1;
          if (32'(fill_r[w_r]) < WINDOW_DEPTH) begin
            fill_r[w_r] <= fill_r[w_r] + 1'b1;
            n_r    <= fill_r[w_r] + 1'b1;
            rcnt_r <= fill_r[w_r] + 1'b1;
          end else begin
            n_r    <= fill_r[w_r];
            rcnt_r <= fill_r[w_r];
          end
          rptr_r <= head_w;
          rvld_r <= 1'b0;
          dcnt_r <= '0;
          sum_r  <= '0;
          sq_r   <= '0;
          rise_r <= 1'b0;
        end
        S_READ: begin
          rvld_r <= (rcnt_r != '0);
          if (rcnt_r != '0) begin
            rcnt_r <= rcnt_r - 1'b1;
            rptr_r <= (rptr_r == '0) ? HW'(WINDOW_DEPTH-1) : rptr_r - 1'b1;
          end
          // Accumulate the entry read last cycle
          if (rvld_r) begin
            sum_r  <= sum_r + SW'(rdata);
            sq_r   <= sq_r + QW'(rdata) * QW'(rdata);
            dcnt_r <= dcnt_r + 1'b1;
            if (dcnt_r == NW'(0)) last1_r <= rdata;
            if (dcnt_r == NW'(1)) last2_r <= rdata;
            if (dcnt_r == NW'(2)) rise_r <= (last2_r > rdata) && (last1_r > last2_r);
          end
        end
        S_JUDGE: begin
          if (jdone && jfire) begin
            out_r.order_instrument <= inst_r;
            out_r.order_price      <= jprice;
            out_r.is_buy           <= jbuy;
            ovld_r                 <= 1'b1;
          end
        end
        S_OUT: begin
          if (out_ready) ovld_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  tws_judge #(.WINDOW_DEPTH(WINDOW_DEPTH), .PRICE_BITS(PRICE_BITS)) u_judge (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (jstart_r),
    .cfg    (cfg_r),
    .price  (price_r),
    .fill   (n_r),
    .sum    (sum_r),
    .sqsum  (sq_r),
    .rising (rise_r),
    .done   (jdone),
    .fire   (jfire),
    .buy    (jbuy),
    .oprice (jprice)
  );

  assign out_valid = ovld_r;
  assign out_data  = out_r;

  `TWS_ASSERT_IMP(a_out_only_in_out, clk, rst_n, ovld_r, st_r == S_OUT, "order word outside output state")
  `TWS_ASSERT_IMP(a_no_take_busy, clk, rst_n, ovld_r, !in_ready, "tick taken with order pending")
  `TWS_ASSERT_NEXT(a_write_then_read, clk, rst_n, st_r == S_WRITE, st_r == S_READ, "read sweep not started")
  `TWS_ASSERT_IMP(a_fill_bound, clk, rst_n, st_r == S_READ, 32'(n_r) <= WINDOW_DEPTH && n_r != '0, "fill out of range")

endmodule
